// ===== rtl/tfq_pkg.sv =====
package tfq_pkg;

    localparam int TAG_W    = 64;
    localparam int REWARD_W = 20;
    localparam int KIND_W   = 8;
    localparam int DUR_W    = 20;
    localparam int THR_W    = 21;
    localparam int SUM_W    = 24;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_ENQUEUE   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DEQUEUE   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK      = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PARTITION = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // One queue entry as it sits in memory
    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [REWARD_W-1:0] reward;
        logic [KIND_W-1:0]   kind;
        logic [DUR_W-1:0]    duration;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/fifo_with_threshold_partition.sv =====
// Bounded task queue with a stable threshold partition.
//
// Request channel (req_valid / req_stall): one request per transfer, req_type
// selects enqueue, dequeue, peek, clear or partition; name_tag, reward, kind
// and duration matter for enqueue, threshold for partition.
// Response channel (rsp_valid / rsp_stall): exactly one response per request,
// in request order: status, the front entry for a successful dequeue or peek,
// and reward_sum for partition. Fields a request does not use read as zero.
//
// One request is in work at a time. Enqueue, dequeue, peek, clear and the
// unused codes go from the request transfer straight to the response state,
// which raises rsp_valid through the output register once the slot is free;
// the front entry comes out of the synchronous entry memory in that state.
// Partition answers after two passes: one pass reads every stored entry,
// packing low entries in place and parking the rest in the spill memory, and
// a second pass copies the spill memory back behind the low entries.
// Reset clears the head, the count and all handshake state; the memories hold
// no reset value. A stalled response is held in the output register; the next
// request is still taken, and its response waits until the held one transfers.
module fifo_with_threshold_partition
    import tfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                req_valid,
    output logic                req_stall,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [TAG_W-1:0]    name_tag,
    input  logic [REWARD_W-1:0] reward,
    input  logic [KIND_W-1:0]   kind,
    input  logic [DUR_W-1:0]    duration,
    input  logic [THR_W-1:0]    threshold,

    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [TAG_W-1:0]    out_tag,
    output logic [REWARD_W-1:0] out_reward,
    output logic [KIND_W-1:0]   out_kind,
    output logic [DUR_W-1:0]    out_duration,
    output logic [SUM_W-1:0]    reward_sum
);

    localparam int ADDR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int POS_W   = ADDR_W + 1;

    localparam logic [ADDR_W-1:0]  LAST_POS  = ADDR_W'(QUEUE_DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(QUEUE_DEPTH);
    localparam logic [POS_W-1:0]   DEPTH_POS = POS_W'(QUEUE_DEPTH);

    // control state
    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    head_reg, head_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    // partition walk
    logic [ADDR_W-1:0]    rd_pos_reg, rd_pos_next;
    logic [ADDR_W-1:0]    wr_pos_reg, wr_pos_next;
    logic [COUNT_W-1:0]   rd_off_reg, rd_off_next;
    logic [COUNT_W-1:0]   spill_cnt_reg, spill_cnt_next;
    logic                 pend_reg, pend_next;
    logic [THR_W-1:0]     thr_reg, thr_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;

    // pending response
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic                 res_show_reg, res_show_next;

    // output register
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    entry_t               out_entry_reg, out_entry_next;
    logic [SUM_W-1:0]     reward_sum_reg, reward_sum_next;

    // memory ports
    logic                 ent_wr_en, ent_rd_en, spl_wr_en, spl_rd_en;
    logic [ADDR_W-1:0]    ent_wr_addr, ent_rd_addr, spl_wr_addr, spl_rd_addr;
    entry_t               ent_wr_data, ent_rd_data, spl_rd_data;

    logic                 accept;
    logic                 slot_free;
    logic                 scan_done;
    logic                 move_done;
    logic [POS_W-1:0]     tail_sum;
    logic [ADDR_W-1:0]    tail_pos;
    logic [SUM_W:0]       sum_ext;
    entry_t               req_entry;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign scan_done = (rd_off_reg == count_reg) && !pend_reg;
    assign move_done = (rd_off_reg == spill_cnt_reg) && !pend_reg;

    // tail = head + count, wrapped into the ring
    assign tail_sum = POS_W'(head_reg) + POS_W'(count_reg);
    assign tail_pos = (tail_sum >= DEPTH_POS) ? ADDR_W'(tail_sum - DEPTH_POS)
                                              : ADDR_W'(tail_sum);

    assign sum_ext  = {1'b0, sum_reg} + (SUM_W + 1)'(ent_rd_data.reward);

    assign req_entry.tag      = name_tag;
    assign req_entry.reward   = reward;
    assign req_entry.kind     = kind;
    assign req_entry.duration = duration;

    tfq_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data)
    );

    tfq_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_spill_ram (
        .clk     (clk),
        .wr_en   (spl_wr_en),
        .wr_addr (spl_wr_addr),
        .wr_data (ent_rd_data),
        .rd_en   (spl_rd_en),
        .rd_addr (spl_rd_addr),
        .rd_data (spl_rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_type == REQ_PARTITION) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE:
            begin
                if (move_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        rd_pos_next     = rd_pos_reg;
        wr_pos_next     = wr_pos_reg;
        rd_off_next     = rd_off_reg;
        spill_cnt_next  = spill_cnt_reg;
        pend_next       = 1'b0;
        thr_next        = thr_reg;
        sum_next        = sum_reg;
        res_status_next = res_status_reg;
        res_show_next   = res_show_reg;

        ent_wr_en   = 1'b0;
        ent_wr_addr = wr_pos_reg;
        ent_wr_data = ent_rd_data;
        ent_rd_en   = 1'b0;
        ent_rd_addr = rd_pos_reg;
        spl_wr_en   = 1'b0;
        spl_wr_addr = spill_cnt_reg[ADDR_W-1:0];
        spl_rd_en   = 1'b0;
        spl_rd_addr = rd_off_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = STATUS_OK;
                    res_show_next   = 1'b0;
                    sum_next        = '0;
                    case (req_type)
                        REQ_ENQUEUE:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ent_wr_en   = 1'b1;
                                ent_wr_addr = tail_pos;
                                ent_wr_data = req_entry;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        REQ_DEQUEUE, REQ_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                // front entry arrives in the response state
                                ent_rd_en     = 1'b1;
                                ent_rd_addr   = head_reg;
                                res_show_next = 1'b1;
                                if (req_type == REQ_DEQUEUE)
                                begin
                                    head_next  = (head_reg == LAST_POS) ? '0
                                                                        : head_reg + 1'b1;
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                        REQ_CLEAR:
                        begin
                            head_next  = '0;
                            count_next = '0;
                        end
                        REQ_PARTITION:
                        begin
                            thr_next       = threshold;
                            rd_pos_next    = head_reg;
                            wr_pos_next    = head_reg;
                            rd_off_next    = '0;
                            spill_cnt_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // issue the next ring read
                if (rd_off_reg != count_reg)
                begin
                    ent_rd_en   = 1'b1;
                    ent_rd_addr = rd_pos_reg;
                    rd_pos_next = (rd_pos_reg == LAST_POS) ? '0 : rd_pos_reg + 1'b1;
                    rd_off_next = rd_off_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                // sort the entry read last cycle; the write slot trails the read
                if (pend_reg)
                begin
                    if ({1'b0, ent_rd_data.duration} < thr_reg)
                    begin
                        ent_wr_en   = 1'b1;
                        ent_wr_addr = wr_pos_reg;
                        ent_wr_data = ent_rd_data;
                        wr_pos_next = (wr_pos_reg == LAST_POS) ? '0 : wr_pos_reg + 1'b1;
                        sum_next    = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
                    end
                    else
                    begin
                        spl_wr_en      = 1'b1;
                        spill_cnt_next = spill_cnt_reg + 1'b1;
                    end
                end
                if (scan_done)
                begin
                    rd_off_next = '0;
                end
            end
            ST_MOVE:
            begin
                if (rd_off_reg != spill_cnt_reg)
                begin
                    spl_rd_en   = 1'b1;
                    rd_off_next = rd_off_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                // append spilled entries behind the low group
                if (pend_reg)
                begin
                    ent_wr_en   = 1'b1;
                    ent_wr_addr = wr_pos_reg;
                    ent_wr_data = spl_rd_data;
                    wr_pos_next = (wr_pos_reg == LAST_POS) ? '0 : wr_pos_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // output register: load in the response state, drop on transfer
    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        status_next     = status_reg;
        out_entry_next  = out_entry_reg;
        reward_sum_next = reward_sum_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if ((state_reg == ST_DONE) && slot_free)
        begin
            rsp_valid_next  = 1'b1;
            status_next     = res_status_reg;
            out_entry_next  = res_show_reg ? ent_rd_data : '0;
            reward_sum_next = sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rd_off_reg    <= '0;
            spill_cnt_reg <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rd_off_reg    <= rd_off_next;
            spill_cnt_reg <= spill_cnt_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pos_reg      <= rd_pos_next;
        wr_pos_reg      <= wr_pos_next;
        thr_reg         <= thr_next;
        sum_reg         <= sum_next;
        res_status_reg  <= res_status_next;
        res_show_reg    <= res_show_next;
        status_reg      <= status_next;
        out_entry_reg   <= out_entry_next;
        reward_sum_reg  <= reward_sum_next;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign out_tag      = out_entry_reg.tag;
    assign out_reward   = out_entry_reg.reward;
    assign out_kind     = out_entry_reg.kind;
    assign out_duration = out_entry_reg.duration;
    assign reward_sum   = reward_sum_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count beyond queue depth");

    a_spill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) || (state_reg == ST_MOVE))
        |-> (spill_cnt_reg <= count_reg))
        else $error("spill count beyond entry count");

    a_dequeue_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == REQ_DEQUEUE) && (count_reg != '0))
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("dequeue did not remove one entry");

    a_partition_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> $stable(count_reg))
        else $error("entry count changed during partition or response");
`endif

endmodule

// ===== rtl/tfq_ram.sv =====
module tfq_ram
    import tfq_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
